// ----- rtl/core/stq_pkg.sv -----
// shared constants and control types for the sorted task queue
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int COUNT_W         = 5;
  localparam int ID_W            = 16;
  localparam int TIME_W          = 32;

  // input command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  // datapath operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       emit;
    logic       last;
  } stq_dp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/stq_datapath.sv -----
// chain of task slots with insert, remove and rotate, plus the result registers
`timescale 1ns / 1ps
`default_nettype none

module stq_datapath #(
  parameter int QUEUE_DEPTH = stq_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire stq_pkg::stq_dp_cmd_t               dp_cmd,
  input  wire logic [stq_pkg::ID_W-1:0]           task_id,
  input  wire logic [stq_pkg::TIME_W-1:0]         task_time,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        count,
  output logic                                    res_valid,
  output logic                                    res_entry_valid,
  output logic [stq_pkg::ID_W-1:0]                res_entry_id,
  output logic [stq_pkg::TIME_W-1:0]              res_entry_time,
  output logic [stq_pkg::COUNT_W-1:0]             res_task_count,
  output logic                                    res_found,
  output logic                                    res_dropped,
  output logic                                    res_last
);

  localparam int D  = QUEUE_DEPTH;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [D-1:0]                occ_r, occ_nxt;
  logic [stq_pkg::ID_W-1:0]    id_r   [D];
  logic [stq_pkg::ID_W-1:0]    id_nxt [D];
  logic [stq_pkg::TIME_W-1:0]  time_r   [D];
  logic [stq_pkg::TIME_W-1:0]  time_nxt [D];
  logic [CW-1:0]               count_r, count_nxt;

  // neighbor views of each cell
  logic [D-1:0]                le, le_lo, match, hit, hit_lo, occ_hi;
  logic [stq_pkg::ID_W-1:0]    id_hi   [D];
  logic [stq_pkg::TIME_W-1:0]  time_hi [D];

  logic                        res_valid_r;
  logic                        res_entry_valid_r;
  logic [stq_pkg::ID_W-1:0]    res_entry_id_r;
  logic [stq_pkg::TIME_W-1:0]  res_entry_time_r;
  logic [stq_pkg::COUNT_W-1:0] res_task_count_r;
  logic                        res_found_r;
  logic                        res_dropped_r;
  logic                        res_last_r;

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      assign le[g]    = occ_r[g] && (time_r[g] <= task_time);
      assign match[g] = occ_r[g] && (id_r[g] == task_id);
      assign hit[g]   = match[g] | hit_lo[g];
      if (g == 0) begin : g_first
        assign le_lo[g]  = 1'b1;
        assign hit_lo[g] = 1'b0;
      end else begin : g_rest
        assign le_lo[g]  = le[g-1];
        assign hit_lo[g] = hit[g-1];
      end
      if (g == D - 1) begin : g_tail
        assign occ_hi[g]  = 1'b0;
        assign id_hi[g]   = '0;
        assign time_hi[g] = '0;
      end else begin : g_body
        assign occ_hi[g]  = occ_r[g+1];
        assign id_hi[g]   = id_r[g+1];
        assign time_hi[g] = time_r[g+1];
      end
    end
  endgenerate

  always_comb begin
    occ_nxt   = occ_r;
    id_nxt    = id_r;
    time_nxt  = time_r;
    count_nxt = count_r;
    for (int i = 0; i < D; i++) begin
      case (dp_cmd.op)
        stq_pkg::OP_INSERT: begin
          if (le[i]) begin
            occ_nxt[i] = occ_r[i];
          end else if (le_lo[i]) begin
            occ_nxt[i]  = 1'b1;
            id_nxt[i]   = task_id;
            time_nxt[i] = task_time;
          end else begin
            // shift along from the cell below
            occ_nxt[i]  = occ_r[(i == 0) ? 0 : i-1];
            id_nxt[i]   = id_r[(i == 0) ? 0 : i-1];
            time_nxt[i] = time_r[(i == 0) ? 0 : i-1];
          end
        end
        stq_pkg::OP_REMOVE: begin
          if (hit[i]) begin
            occ_nxt[i]  = occ_hi[i];
            id_nxt[i]   = id_hi[i];
            time_nxt[i] = time_hi[i];
          end
        end
        stq_pkg::OP_ROTATE: begin
          // rotate the occupied run by one, head wraps to its end
          if (occ_hi[i]) begin
            id_nxt[i]   = id_hi[i];
            time_nxt[i] = time_hi[i];
          end else if (occ_r[i]) begin
            id_nxt[i]   = id_r[0];
            time_nxt[i] = time_r[0];
          end
        end
        default: begin
          occ_nxt[i] = occ_r[i];
        end
      endcase
    end
    if (dp_cmd.op == stq_pkg::OP_INSERT && !occ_r[D-1]) begin
      count_nxt = count_r + CW'(1);
    end else if (dp_cmd.op == stq_pkg::OP_REMOVE && hit[D-1]) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      count_r     <= count_nxt;
      res_valid_r <= dp_cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    time_r <= time_nxt;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      res_task_count_r <= stq_pkg::COUNT_W'(count_nxt);
      res_last_r       <= dp_cmd.last;
      res_found_r      <= (dp_cmd.op == stq_pkg::OP_REMOVE) && hit[D-1];
      res_dropped_r    <= (dp_cmd.op == stq_pkg::OP_INSERT) && occ_r[D-1];
      if ((dp_cmd.op == stq_pkg::OP_HOLD || dp_cmd.op == stq_pkg::OP_ROTATE) && occ_r[0]) begin
        res_entry_valid_r <= 1'b1;
        res_entry_id_r    <= id_r[0];
        res_entry_time_r  <= time_r[0];
      end else begin
        res_entry_valid_r <= 1'b0;
        res_entry_id_r    <= '0;
        res_entry_time_r  <= '0;
      end
    end
  end

  assign count           = count_r;
  assign res_valid       = res_valid_r;
  assign res_entry_valid = res_entry_valid_r;
  assign res_entry_id    = res_entry_id_r;
  assign res_entry_time  = res_entry_time_r;
  assign res_task_count  = res_task_count_r;
  assign res_found       = res_found_r;
  assign res_dropped     = res_dropped_r;
  assign res_last        = res_last_r;

  // occupied slots form one run from the head
  a_occ_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_r >> 1) & ~occ_r) == '0)
    else $error("gap in occupied slots");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_r) == int'(count_r))
    else $error("count disagrees with occupied slots");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == stq_pkg::OP_INSERT && !occ_r[D-1]) |=>
      count_r == $past(count_r) + CW'(1))
    else $error("insert into a non-full list did not grow it");

  a_rotate_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == stq_pkg::OP_ROTATE) |=> $stable(occ_r))
    else $error("rotation changed occupancy");

endmodule

`default_nettype wire

// ----- rtl/core/stq_ctrl.sv -----
// command sequencer: insert, remove and peek commands and the dump walk
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl #(
  parameter int QUEUE_DEPTH = stq_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [1:0]                   cmd,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
  output logic                              busy,
  output stq_pkg::stq_dp_cmd_t              dp_cmd
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    dp_cmd.op   = stq_pkg::OP_HOLD;
    dp_cmd.emit = 1'b0;
    dp_cmd.last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          dp_cmd.emit = 1'b1;
          dp_cmd.last = 1'b1;
          unique case (cmd)
            stq_pkg::CMD_INSERT: dp_cmd.op = stq_pkg::OP_INSERT;
            stq_pkg::CMD_REMOVE: dp_cmd.op = stq_pkg::OP_REMOVE;
            stq_pkg::CMD_PEEK:   dp_cmd.op = stq_pkg::OP_HOLD;
            default: begin
              // dump: walk the run by rotating it count times
              if (count > CW'(1)) begin
                dp_cmd.op   = stq_pkg::OP_ROTATE;
                dp_cmd.last = 1'b0;
                rem_nxt     = count - CW'(1);
                state_nxt   = ST_DUMP;
              end
            end
          endcase
        end
      end
      default: begin
        dp_cmd.op   = stq_pkg::OP_ROTATE;
        dp_cmd.emit = 1'b1;
        dp_cmd.last = (rem_r == CW'(1));
        rem_nxt     = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign busy = (state_r == ST_DUMP);

  a_accept_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> dp_cmd.emit)
    else $error("accepted command produced no result");

  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && dp_cmd.last) |=> !busy)
    else $error("dump kept running after its last entry");

endmodule

`default_nettype wire

// ----- rtl/core/sorted_task_queue_core.sv -----
// Sorted task queue: QUEUE_DEPTH slots kept in ascending time order, equal
// times in arrival order. A command is taken when start is high and busy is
// low. Insert, remove and peek may follow back to back; their single result
// appears on the out_ ports in the cycle after the transfer. A dump of n
// occupied entries keeps busy high while it walks and gives max(n,1)
// results, one per cycle, head first, out_last on the final one; the slot
// chain rotates one entry per cycle to bring each entry to the head.
// out_valid marks each result for exactly one cycle and the receiver cannot
// stall it.
`timescale 1ns / 1ps
`default_nettype none

module sorted_task_queue_core #(
  parameter int QUEUE_DEPTH = stq_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [stq_pkg::ID_W-1:0]    in_task_id,
  input  wire logic [stq_pkg::TIME_W-1:0]  in_task_time,
  output logic                             out_valid,
  output logic                             out_entry_valid,
  output logic [stq_pkg::ID_W-1:0]         out_entry_id,
  output logic [stq_pkg::TIME_W-1:0]       out_entry_time,
  output logic [stq_pkg::COUNT_W-1:0]      out_task_count,
  output logic                             out_found,
  output logic                             out_dropped,
  output logic                             out_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  stq_pkg::stq_dp_cmd_t dp_cmd;
  logic [CW-1:0]        count;

  stq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (in_cmd),
    .count  (count),
    .busy   (busy),
    .dp_cmd (dp_cmd)
  );

  stq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .task_id         (in_task_id),
    .task_time       (in_task_time),
    .count           (count),
    .res_valid       (out_valid),
    .res_entry_valid (out_entry_valid),
    .res_entry_id    (out_entry_id),
    .res_entry_time  (out_entry_time),
    .res_task_count  (out_task_count),
    .res_found       (out_found),
    .res_dropped     (out_dropped),
    .res_last        (out_last)
  );

endmodule

`default_nettype wire
